// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owa assertion failed");

// Next-cycle implication, disabled during reset.
`define OWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owa assertion failed");

`endif

// File: hw/rtl/owa_pkg.sv
// Types and constants of the weighted oil wear accumulator.
// No dependencies.
package owa_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_IGN_ON  = 3'd1,
        OP_IGN_OFF = 3'd2,
        OP_RESET   = 3'd3,
        OP_LOAD    = 3'd4,
        OP_STORE   = 3'd5
    } op_t;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFER_OIL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MILLIONS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OIL_MULTS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLANT_MULTS   = 3'd4;

    localparam int CFG_DATA_W = 64;
    localparam logic [63:0] MULT_RESET = 64'h0100_0100_0100_0100;
    localparam logic [7:0]  SCALE_RESET = 8'd10;

    localparam int TEMP_W = 13;
    localparam logic signed [TEMP_W-1:0] ZONE_COLD_MAX     = 13'sd1120;
    localparam logic signed [TEMP_W-1:0] ZONE_OPTIMAL_MAX  = 13'sd1680;
    localparam logic signed [TEMP_W-1:0] ZONE_HIGH_MAX     = 13'sd2000;

    localparam int MULT_W  = 16;
    localparam int PROD_W  = 48;
    localparam int FRAC_W  = 8;
    localparam int FULL_W  = 28;
    localparam int LIFE_W  = 10;
    localparam int DIV_STEPS = 10;
    localparam int NUM_W   = FULL_W + LIFE_W;
    localparam int DIV_W   = FULL_W + DIV_STEPS - 1;
    localparam int STEP_W  = 4;
    localparam logic [19:0] REVS_PER_MILLION = 20'd1000000;
    localparam logic [LIFE_W-1:0] LIFE_FULL = 10'd1000;

    typedef struct packed {
        logic        monitor_enable;
        logic        prefer_oil_source;
        logic [7:0]  scale_millions;
        logic [63:0] oil_zone_multipliers;
        logic [63:0] coolant_zone_multipliers;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [31:0]       rev;
        logic              use_coolant;
        logic [MULT_W-1:0] mult;
        logic [31:0]       stored;
    } cmd_t;

    typedef struct packed {
        logic [LIFE_W-1:0] life;
        logic              coolant;
        logic [31:0]       total;
        logic [31:0]       drive;
        logic              save_pending;
        logic              flush;
        logic              awaiting_load;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_ACC,
        S_FULL,
        S_DIFF,
        S_SCALE,
        S_DIV,
        S_DONE
    } back_state_t;

endpackage

// File: hw/rtl/owa_front.sv
// Front end: accepts input transactions, picks source, zone and multiplier.
// Depends on owa_pkg.
module owa_front
    import owa_pkg::*;
(
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                opcode,
    input  logic [31:0]               rev_counter,
    input  logic signed [TEMP_W-1:0]  oil_temp,
    input  logic                      oil_temp_valid,
    input  logic signed [TEMP_W-1:0]  coolant_temp,
    input  logic                      coolant_temp_valid,
    input  logic [31:0]               stored_count,
    input  logic                      stored_count_valid,
    input  logic                      q_full,
    output logic                      push,
    output cmd_t                      push_data
);

    logic                     use_coolant;
    logic signed [TEMP_W-1:0] temp;
    logic [1:0]               zone;
    logic [63:0]              mults;
    logic [MULT_W-1:0]        mult;

    always_comb
    begin
        if (cfg.prefer_oil_source && oil_temp_valid)
        begin
            use_coolant = 1'b0;
            temp = oil_temp;
        end
        else if (!cfg.prefer_oil_source && coolant_temp_valid)
        begin
            use_coolant = 1'b1;
            temp = coolant_temp;
        end
        else if (cfg.prefer_oil_source)
        begin
            use_coolant = 1'b1;
            temp = coolant_temp_valid ? coolant_temp : '0;
        end
        else
        begin
            use_coolant = 1'b0;
            temp = oil_temp_valid ? oil_temp : '0;
        end
    end

    always_comb
    begin
        if (temp < ZONE_COLD_MAX)
            zone = 2'd0;
        else if (temp < ZONE_OPTIMAL_MAX)
            zone = 2'd1;
        else if (temp < ZONE_HIGH_MAX)
            zone = 2'd2;
        else
            zone = 2'd3;
    end

    assign mults = use_coolant ? cfg.coolant_zone_multipliers : cfg.oil_zone_multipliers;

    always_comb
    begin
        case (zone)
            2'd0:    mult = mults[15:0];
            2'd1:    mult = mults[31:16];
            2'd2:    mult = mults[47:32];
            default: mult = mults[63:48];
        endcase
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_data.op          = op_t'(opcode);
        push_data.rev         = rev_counter;
        push_data.use_coolant = use_coolant;
        push_data.mult        = mult;
        push_data.stored      = stored_count_valid ? stored_count : '0;
    end

endmodule

// File: hw/rtl/owa_queue.sv
// Command queue between front and back end.
// Depends on owa_pkg.
module owa_queue
    import owa_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hw/rtl/owa_back.sv
// Back end: executes commands, accumulates wear, divides out remaining life.
// Depends on owa_pkg.
module owa_back
    import owa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_valid,
    input  cmd_t q_data,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t res
);

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [31:0]       last_revs_reg, last_revs_next;
    logic [31:0]       total_reg, total_next;
    logic [31:0]       drive_reg, drive_next;
    logic              coolant_reg, coolant_next;
    logic              load_wait_reg, load_wait_next;
    logic              save_wait_reg, save_wait_next;
    logic              flush_reg, flush_next;
    logic [31:0]       delta_reg, delta_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [FULL_W-1:0] full_reg, full_next;
    logic [FULL_W-1:0] diff_reg, diff_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dv_reg, dv_next;
    logic [LIFE_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;
    logic [31:0]       add;
    logic              fits;

    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign add       = prod_reg[FRAC_W +: 32];
    assign fits      = rem_reg >= {1'b0, dv_reg};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        last_revs_next = last_revs_reg;
        total_next     = total_reg;
        drive_next     = drive_reg;
        coolant_next   = coolant_reg;
        load_wait_next = load_wait_reg;
        save_wait_next = save_wait_reg;
        flush_next     = flush_reg;
        delta_next     = delta_reg;
        prod_next      = prod_reg;
        full_next      = full_reg;
        diff_next      = diff_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next   = q_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                flush_next = 1'b0;
                state_next = S_FULL;
                case (cmd_reg.op)
                    OP_TICK:
                    begin
                        if (cfg.monitor_enable && !load_wait_reg)
                        begin
                            delta_next     = cmd_reg.rev - last_revs_reg;
                            last_revs_next = cmd_reg.rev;
                            state_next     = S_MUL;
                        end
                    end
                    OP_IGN_ON:
                        drive_next = '0;
                    OP_IGN_OFF:
                    begin
                        save_wait_next = 1'b1;
                        flush_next     = 1'b1;
                    end
                    OP_RESET:
                    begin
                        total_next     = '0;
                        save_wait_next = 1'b1;
                        flush_next     = 1'b1;
                    end
                    OP_LOAD:
                    begin
                        total_next     = cmd_reg.stored;
                        load_wait_next = 1'b0;
                        last_revs_next = cmd_reg.rev;
                    end
                    OP_STORE:
                        save_wait_next = 1'b0;
                    default:
                    begin
                    end
                endcase
            end
            S_MUL:
            begin
                if (delta_reg != '0)
                begin
                    coolant_next = cmd_reg.use_coolant;
                    prod_next    = PROD_W'(delta_reg) * PROD_W'(cmd_reg.mult);
                    state_next   = S_ACC;
                end
                else
                    state_next = S_FULL;
            end
            S_ACC:
            begin
                total_next = total_reg + add;
                drive_next = drive_reg + add;
                state_next = S_FULL;
            end
            S_FULL:
            begin
                full_next  = FULL_W'(cfg.scale_millions) * FULL_W'(REVS_PER_MILLION);
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                if (cfg.scale_millions == '0)
                begin
                    quo_next   = LIFE_FULL;
                    state_next = S_DONE;
                end
                else if (total_reg >= 32'(full_reg))
                begin
                    quo_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    diff_next  = full_reg - total_reg[FULL_W-1:0];
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                rem_next   = NUM_W'(diff_reg) * NUM_W'(LIFE_FULL);
                dv_next    = {full_reg, {(DIV_STEPS - 1){1'b0}}};
                quo_next   = '0;
                step_next  = STEP_W'(DIV_STEPS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (fits)
                    rem_next = rem_reg - NUM_W'(dv_reg);
                quo_next = {quo_reg[LIFE_W-2:0], fits};
                dv_next  = dv_reg >> 1;
                if (step_reg == '0)
                    state_next = S_DONE;
                else
                    step_next = step_reg - 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_next.life          = quo_reg;
                    res_next.coolant       = coolant_reg;
                    res_next.total         = total_reg;
                    res_next.drive         = drive_reg;
                    res_next.save_pending  = save_wait_reg;
                    res_next.flush         = flush_reg;
                    res_next.awaiting_load = load_wait_reg;
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_revs_reg <= '0;
            total_reg     <= '0;
            drive_reg     <= '0;
            coolant_reg   <= 1'b0;
            load_wait_reg <= 1'b1;
            save_wait_reg <= 1'b0;
            flush_reg     <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_revs_reg <= last_revs_next;
            total_reg     <= total_next;
            drive_reg     <= drive_next;
            coolant_reg   <= coolant_next;
            load_wait_reg <= load_wait_next;
            save_wait_reg <= save_wait_next;
            flush_reg     <= flush_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        delta_reg <= delta_next;
        prod_reg  <= prod_next;
        full_reg  <= full_next;
        diff_reg  <= diff_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_next;
        quo_reg   <= quo_next;
        res_reg   <= res_next;
    end

endmodule

// File: hw/rtl/weighted_oil_wear_accumulator_core.sv
// Channel  | handshake              | payload
// cfg      | cfg_write              | cfg_index, cfg_data
// input    | in_valid / in_ready    | opcode .. stored_count_valid
// result   | out_valid / out_ready  | life_tenths_percent .. awaiting_load
//
// From queue pop to result register, a tick that adds wear passes EXEC, MUL, ACC, FULL, DIFF, SCALE,
// the 10-step restoring divider for the life figure and DONE; a zero delta skips ACC, other opcodes or
// an idle tick skip MUL and ACC, and a clamped life or a zero scale skips SCALE and the divider.
// Reset empties the command queue, drops any waiting result, clears wear state; config returns to defaults.
// A waiting result stalls only the last back-end step; the queue takes transactions until full.
//
// Top level of the weighted oil wear accumulator; holds the config registers.
// Depends on owa_pkg, owa_front, owa_queue, owa_back.
module weighted_oil_wear_accumulator_core
    import owa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                opcode,
    input  logic [31:0]               rev_counter,
    input  logic signed [TEMP_W-1:0]  oil_temp,
    input  logic                      oil_temp_valid,
    input  logic signed [TEMP_W-1:0]  coolant_temp,
    input  logic                      coolant_temp_valid,
    input  logic [31:0]               stored_count,
    input  logic                      stored_count_valid,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [LIFE_W-1:0]         life_tenths_percent,
    output logic                      source_is_coolant,
    output logic [31:0]               weighted_total,
    output logic [31:0]               weighted_drive,
    output logic                      save_pending,
    output logic                      flush_request,
    output logic                      awaiting_load
);

    cfg_t cfg_reg, cfg_next;
    logic q_full;
    logic q_push;
    cmd_t q_push_data;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_pop_data;
    res_t res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MONITOR_ENABLE: cfg_next.monitor_enable           = cfg_data[0];
                CFG_PREFER_OIL:     cfg_next.prefer_oil_source        = cfg_data[0];
                CFG_SCALE_MILLIONS: cfg_next.scale_millions           = cfg_data[7:0];
                CFG_OIL_MULTS:      cfg_next.oil_zone_multipliers     = cfg_data;
                CFG_COOLANT_MULTS:  cfg_next.coolant_zone_multipliers = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.monitor_enable           <= 1'b0;
            cfg_reg.prefer_oil_source        <= 1'b1;
            cfg_reg.scale_millions           <= SCALE_RESET;
            cfg_reg.oil_zone_multipliers     <= MULT_RESET;
            cfg_reg.coolant_zone_multipliers <= MULT_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    owa_front u_front (
        .cfg                (cfg_reg),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .rev_counter        (rev_counter),
        .oil_temp           (oil_temp),
        .oil_temp_valid     (oil_temp_valid),
        .coolant_temp       (coolant_temp),
        .coolant_temp_valid (coolant_temp_valid),
        .stored_count       (stored_count),
        .stored_count_valid (stored_count_valid),
        .q_full             (q_full),
        .push               (q_push),
        .push_data          (q_push_data)
    );

    owa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    owa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_data    (q_pop_data),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign life_tenths_percent = res.life;
    assign source_is_coolant   = res.coolant;
    assign weighted_total      = res.total;
    assign weighted_drive      = res.drive;
    assign save_pending        = res.save_pending;
    assign flush_request       = res.flush;
    assign awaiting_load       = res.awaiting_load;

endmodule

// File: hw/rtl/owa_checker.sv
// Port-level checks for the weighted oil wear accumulator, bound to the top level.
// Depends on owa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module owa_checker
    import owa_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [LIFE_W-1:0]         life_tenths_percent,
    input logic [31:0]               weighted_total,
    input logic                      save_pending,
    input logic                      flush_request
);

    `OWA_ASSERT_NXT(a_result_held, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(weighted_total) && $stable(life_tenths_percent))

    `OWA_ASSERT_IMP(a_life_range, clk, rst_n, out_valid, life_tenths_percent <= LIFE_FULL)

    `OWA_ASSERT_IMP(a_zero_wear_full_life, clk, rst_n, out_valid && weighted_total == '0,
        life_tenths_percent == LIFE_FULL)

    `OWA_ASSERT_IMP(a_flush_sets_pending, clk, rst_n, out_valid && flush_request,
        save_pending)

endmodule

bind weighted_oil_wear_accumulator_core owa_checker u_owa_checker (.*);
